// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

   localparam int PRI_WIDTH       = 16;
   localparam int VALUE_FIELD_W   = 32;
   localparam int COUNT_FIELD_W   = 5;
   localparam int REQ_TDATA_WIDTH = 48;
   localparam int RSP_TDATA_WIDTH = 56;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef struct packed {
      logic                 enq;
      logic                 deq;
      logic [PRI_WIDTH-1:0] new_pri;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
`default_nettype none

module spq_cell
   import spq_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire cell_ctl_type         ctl,
   input  wire logic [WIDTH-1:0]     new_value,
   input  wire logic                 occupied,
   input  wire logic                 prev_ge,
   input  wire logic [WIDTH-1:0]     prev_value,
   input  wire logic [PRI_WIDTH-1:0] prev_pri,
   input  wire logic [WIDTH-1:0]     next_value,
   input  wire logic [PRI_WIDTH-1:0] next_pri,
   output logic                      ge,
   output logic [WIDTH-1:0]          value,
   output logic [PRI_WIDTH-1:0]      pri
);

   logic [WIDTH-1:0]     value_ff;
   logic [WIDTH-1:0]     value_in;
   logic [PRI_WIDTH-1:0] pri_ff;
   logic [PRI_WIDTH-1:0] pri_in;
   logic                 load;

   assign ge    = !occupied || (pri_ff >= ctl.new_pri);
   assign value = value_ff;
   assign pri   = pri_ff;

   always_comb begin
      load     = 1'b0;
      value_in = value_ff;
      pri_in   = pri_ff;
      priority if (ctl.enq && prev_ge) begin
         // shift down behind the inserted entry
         load     = 1'b1;
         value_in = prev_value;
         pri_in   = prev_pri;
      end else if (ctl.enq && ge) begin
         // insert here
         load     = 1'b1;
         value_in = new_value;
         pri_in   = ctl.new_pri;
      end else if (ctl.deq) begin
         // advance toward the head
         load     = 1'b1;
         value_in = next_value;
         pri_in   = next_pri;
      end else begin
         // hold
         load     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
         pri_ff   <= pri_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_top.sv =====
`default_nettype none
// Results are registered: a result appears on the rsp side in the cycle after its request transaction.
// Throughput: one transaction per cycle while rsp_tready holds; every cell compares and shifts in parallel,
// so insert and remove both finish in the cycle of acceptance.
// Reset: synchronous, active high; clears the entry count and the result valid flag.
// Cell contents are not cleared and are only read below the entry count.

module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // [31:0] item_value, [47:32] item_priority
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // [0] func
   input  wire logic                       req_tuser,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [31:0] out_value, [47:32] out_priority, [48] dropped, [49] now_empty,
   // [54:50] now_count, [55] zero
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata,
   // [0] out_valid
   output logic                            rsp_tuser
);

   localparam int SW = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic                       rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_in;
   logic                       rsp_user_ff;
   logic                       rsp_user_in;

   logic                       accept;
   logic                       full;
   logic                       empty;
   op_type                     op;
   logic [SW-1:0]              new_value;
   logic [PRI_WIDTH-1:0]       new_pri;
   cell_ctl_type               ctl;

   logic [DEPTH-1:0]           cell_ge;
   logic [DEPTH-1:0]           cell_occ;
   logic [SW-1:0]              cell_value [DEPTH];
   logic [PRI_WIDTH-1:0]       cell_pri   [DEPTH];

   logic                       dropped;
   logic                       out_valid;
   logic [VALUE_FIELD_W-1:0]   out_value;
   logic [PRI_WIDTH-1:0]       out_pri;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign new_value  = req_tdata[SW-1:0];
   assign new_pri    = req_tdata[VALUE_FIELD_W +: PRI_WIDTH];
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);

   assign ctl.enq     = accept && (op == OP_ENQUEUE) && !full;
   assign ctl.deq     = accept && (op == OP_DEQUEUE) && !empty;
   assign ctl.new_pri = new_pri;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                 prev_ge;
      logic [SW-1:0]        prev_value;
      logic [PRI_WIDTH-1:0] prev_pri;
      logic [SW-1:0]        next_value;
      logic [PRI_WIDTH-1:0] next_pri;

      assign cell_occ[g] = (count_ff > CW'(g));

      if (g == 0) begin : g_head
         assign prev_ge    = 1'b0;
         assign prev_value = '0;
         assign prev_pri   = '0;
      end else begin : g_body
         assign prev_ge    = cell_ge[g-1];
         assign prev_value = cell_value[g-1];
         assign prev_pri   = cell_pri[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[g];
         assign next_pri   = cell_pri[g];
      end else begin : g_inner
         assign next_value = cell_value[g+1];
         assign next_pri   = cell_pri[g+1];
      end

      spq_cell #(
         .WIDTH (SW)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_value  (new_value),
         .occupied   (cell_occ[g]),
         .prev_ge    (prev_ge),
         .prev_value (prev_value),
         .prev_pri   (prev_pri),
         .next_value (next_value),
         .next_pri   (next_pri),
         .ge         (cell_ge[g]),
         .value      (cell_value[g]),
         .pri        (cell_pri[g])
      );
   end

   always_comb begin
      count_in  = count_ff;
      dropped   = 1'b0;
      out_valid = 1'b0;
      out_value = '0;
      out_pri   = '0;
      unique case (op)
         OP_ENQUEUE: begin
            if (full) begin
               dropped = 1'b1;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         OP_DEQUEUE: begin
            if (!empty) begin
               out_valid = 1'b1;
               out_value = VALUE_FIELD_W'(cell_value[0]);
               out_pri   = cell_pri[0];
               count_in  = count_ff - CW'(1);
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_data_in = {1'b0, COUNT_FIELD_W'(count_in), (count_in == '0), dropped,
                     out_pri, out_value};
      rsp_user_in = out_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      ctl.enq |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not advance count");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (cell_pri[0] <= cell_pri[1]))
      else $error("head entries out of order");

   a_valid_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff && rsp_data_ff[VALUE_FIELD_W + PRI_WIDTH]))
      else $error("result both valid and dropped");

endmodule

`default_nettype wire

// ===== sim/spq_result_checker.sv =====
`default_nettype none

module spq_result_checker
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tready,
   // [31:0] item_value, [47:32] item_priority
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // [0] func
   input  wire logic                       req_tuser,
   input  wire logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   // [31:0] out_value, [47:32] out_priority, [48] dropped, [49] now_empty,
   // [54:50] now_count, [55] zero
   input  wire logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // [0] out_valid
   input  wire logic                       rsp_tuser,
   output int                              mismatch_count,
   output int                              outstanding
);

   typedef struct packed {
      logic [VALUE_FIELD_W-1:0] value;
      logic [PRI_WIDTH-1:0]     pri;
      logic                     valid;
      logic                     dropped;
      logic                     empty;
      logic [COUNT_FIELD_W-1:0] count;
   } queue_result_type;

   logic [VALUE_FIELD_W-1:0] slot_value [DEPTH];
   logic [PRI_WIDTH-1:0]     slot_pri   [DEPTH];
   int                       held;
   queue_result_type         pending_results [$];

   function automatic queue_result_type predict_queue_op(
      input op_type                   op,
      input logic [VALUE_FIELD_W-1:0] val,
      input logic [PRI_WIDTH-1:0]     pri
   );
      queue_result_type r;
      int               pos;
      r = '0;
      if (op == OP_ENQUEUE) begin
         if (held >= DEPTH) begin
            r.dropped = 1'b1;
         end else begin
            pos = 0;
            while (pos < held && slot_pri[pos] < pri) pos++;
            for (int i = held; i > pos; i--) begin
               slot_value[i] = slot_value[i-1];
               slot_pri[i]   = slot_pri[i-1];
            end
            slot_value[pos] = val;
            slot_pri[pos]   = pri;
            held++;
         end
      end else if (held > 0) begin
         r.value = slot_value[0];
         r.pri   = slot_pri[0];
         r.valid = 1'b1;
         for (int i = 0; i + 1 < held; i++) begin
            slot_value[i] = slot_value[i+1];
            slot_pri[i]   = slot_pri[i+1];
         end
         held--;
      end
      r.empty = (held == 0);
      r.count = COUNT_FIELD_W'(held);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_result_type want;
      queue_result_type got;
      if (reset) begin
         held = 0;
         mismatch_count = 0;
         pending_results.delete();
      end else begin
         // retire the result first: it belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            got.value   = rsp_tdata[31:0];
            got.pri     = rsp_tdata[47:32];
            got.dropped = rsp_tdata[48];
            got.empty   = rsp_tdata[49];
            got.count   = rsp_tdata[54:50];
            got.valid   = rsp_tuser;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result transaction tdata=%h tuser=%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = pending_results.pop_front();
               if (got !== want || rsp_tdata[55] !== 1'b0) begin
                  mismatch_count++;
                  $display("%0t: expected value=%h pri=%h valid=%b drop=%b empty=%b count=%0d",
                           $time, want.value, want.pri, want.valid, want.dropped,
                           want.empty, want.count);
                  $display("%0t: got value=%h pri=%h valid=%b drop=%b empty=%b count=%0d pad=%b",
                           $time, got.value, got.pri, got.valid, got.dropped, got.empty,
                           got.count, rsp_tdata[55]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_results.push_back(predict_queue_op(op_type'(req_tuser),
                                                       req_tdata[31:0],
                                                       req_tdata[47:32]));
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

`default_nettype wire

// ===== sim/tb_sorted_priority_queue_top.sv =====
`default_nettype none

module tb_sorted_priority_queue_top;
   import spq_pkg::*;

   localparam int DEPTH = 16;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic                       req_tuser = OP_ENQUEUE;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       rsp_tuser;
   int                         mismatch_count;
   int                         outstanding;
   int                         send_idle_pct = 0;
   int                         recv_idle_pct = 0;

   sorted_priority_queue_top #(.DEPTH(DEPTH), .VALUE_WIDTH(32)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   spq_result_checker #(.DEPTH(DEPTH)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .mismatch_count(mismatch_count),
      .outstanding   (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic issue_op(input op_type op, input logic [31:0] val, input logic [15:0] pri);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {pri, val};
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      int          enq_bias;
      op_type      op;
      logic [31:0] val;
      logic [15:0] pri;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 88 : 0;
         recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 9 : 0;
         if (phase == 0) begin
            issue_op(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
            issue_op(OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
            issue_op(OP_ENQUEUE, 32'h0000_0000, 16'h0000);
            issue_op(OP_ENQUEUE, 32'h1234_5678, 16'h0100);
            issue_op(OP_ENQUEUE, 32'hA5A5_A5A5, 16'h0100);
            issue_op(OP_ENQUEUE, 32'h5A5A_5A5A, 16'h0100);
            repeat (6) issue_op(OP_DEQUEUE, 32'h0, 16'h0);
            // fill to the top, then overflow
            for (int k = 0; k < DEPTH; k++)
               issue_op(OP_ENQUEUE, $urandom, 16'((k * 37) % 11));
            issue_op(OP_ENQUEUE, 32'hDEAD_BEEF, 16'h0000);
         end
         enq_bias = 50;
         for (int n = 0; n < 150; n++) begin
            if (n % 25 == 0) begin
               case ($urandom_range(2))
                  0: enq_bias = 80;
                  1: enq_bias = 20;
                  default: enq_bias = 50;
               endcase
            end
            op  = ($urandom_range(99) < enq_bias) ? OP_ENQUEUE : OP_DEQUEUE;
            val = $urandom;
            case ($urandom_range(3))
               0: pri = 16'($urandom_range(7));
               1: pri = 16'($urandom);
               2: pri = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               default: pri = 16'h8000 + 16'($urandom_range(3));
            endcase
            issue_op(op, val, pri);
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
